// ----- src/bsc_pkg.sv -----
// Shared constants, command codes and controller/datapath interface structs
// for the Banker's safety check block. Depends on nothing else.
package bsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 8;
  localparam int VALUE_BITS    = 16;

  localparam int PID_BITS      = 4;
  localparam int RID_BITS      = 3;
  localparam int CNT_BITS      = $clog2(MAX_PROCESSES + 1);
  localparam int NRES_BITS     = $clog2(MAX_RESOURCES + 1);
  localparam int WORK_BITS     = VALUE_BITS + $clog2(MAX_PROCESSES) + 1;
  localparam int ADDR_BITS     = PID_BITS + RID_BITS;
  localparam int TABLE_DEPTH   = 1 << ADDR_BITS;

  localparam int CMD_BITS      = 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;
  localparam int NP_REG_BITS   = 5;
  localparam int NR_REG_BITS   = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD_AVAIL = 2'd0,
    CMD_LOAD_PROC  = 2'd1,
    CMD_RUN        = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_PROC = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_RES  = 1'b1;

  typedef struct packed {
    logic load;
    logic init_run;
    logic p_next;
    logic p_clear;
    logic r_next;
    logic r_clear;
    logic work_add;
    logic commit;
    logic out_load_seq;
    logic out_load_unsafe;
  } ctl_cmd_t;

  typedef struct packed {
    logic all_done;
    logic p_end;
    logic p_finished;
    logic r_last;
    logic fits;
    logic out_last;
  } dp_stat_t;

endpackage

// ----- src/bsc_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing else.
module bsc_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bsc_datapath.sv -----
// Datapath of the Banker's safety check: count registers, tables, work vector,
// finished flags, safe sequence and output payload. Uses bsc_pkg and bsc_ram.
module bsc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsc_pkg::ctl_cmd_t                 cmd_i,
  output bsc_pkg::dp_stat_t                 stat_o,
  input  logic                              cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [bsc_pkg::CMD_BITS-1:0]      command_i,
  input  logic [bsc_pkg::PID_BITS-1:0]      process_index_i,
  input  logic [bsc_pkg::RID_BITS-1:0]      resource_index_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    available_value_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    allocated_value_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    maximum_value_i,
  output logic [bsc_pkg::PID_BITS-1:0]      process_id_o,
  output logic                              safe_o,
  output logic                              last_o
);
  import bsc_pkg::*;

  logic [NP_REG_BITS-1:0] np_reg_q;
  logic [NR_REG_BITS-1:0] nr_reg_q;
  logic [CNT_BITS-1:0]    np;
  logic [NRES_BITS-1:0]   nr;

  logic [VALUE_BITS-1:0]  avail_q [MAX_RESOURCES];
  logic [WORK_BITS-1:0]   work_q [MAX_RESOURCES];
  logic [PID_BITS-1:0]    order_q [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] finished_q;
  logic [CNT_BITS-1:0]    p_q;
  logic [RID_BITS-1:0]    r_q;
  logic [CNT_BITS-1:0]    count_q;
  logic [PID_BITS-1:0]    k_q;

  logic [PID_BITS-1:0]    pid_out_q;
  logic                   safe_out_q;
  logic                   last_out_q;

  logic                   avail_we;
  logic                   table_we;
  logic [ADDR_BITS-1:0]   table_addr;
  logic [VALUE_BITS-1:0]  alloc_rd;
  logic [VALUE_BITS-1:0]  max_rd;
  logic [VALUE_BITS-1:0]  need;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_reg_q <= NP_REG_BITS'(1);
      nr_reg_q <= NR_REG_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_PROC: np_reg_q <= cfg_data_i[NP_REG_BITS-1:0];
        CFG_NUM_RES:  nr_reg_q <= cfg_data_i[NR_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Counts of zero run as one; counts above the table size saturate.
  always_comb begin
    if (np_reg_q == '0) begin
      np = CNT_BITS'(1);
    end else if (CNT_BITS'(np_reg_q) > CNT_BITS'(MAX_PROCESSES)) begin
      np = CNT_BITS'(MAX_PROCESSES);
    end else begin
      np = CNT_BITS'(np_reg_q);
    end
    if (nr_reg_q == '0) begin
      nr = NRES_BITS'(1);
    end else if (NRES_BITS'(nr_reg_q) > NRES_BITS'(MAX_RESOURCES)) begin
      nr = NRES_BITS'(MAX_RESOURCES);
    end else begin
      nr = NRES_BITS'(nr_reg_q);
    end
  end

  always_comb begin
    avail_we = 1'b0;
    table_we = 1'b0;
    if (cmd_i.load) begin
      case (command_i)
        CMD_LOAD_AVAIL: begin
          avail_we = NRES_BITS'(resource_index_i) < NRES_BITS'(MAX_RESOURCES);
        end
        CMD_LOAD_PROC: begin
          table_we = (CNT_BITS'(process_index_i) < CNT_BITS'(MAX_PROCESSES)) &&
                     (NRES_BITS'(resource_index_i) < NRES_BITS'(MAX_RESOURCES));
        end
        default: ;
      endcase
    end
  end

  assign table_addr = cmd_i.load ? {process_index_i, resource_index_i}
                                 : {p_q[PID_BITS-1:0], r_q};

  bsc_ram #(
    .Width(VALUE_BITS),
    .Depth(TABLE_DEPTH)
  ) u_alloc_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .addr_i (table_addr),
    .wdata_i(allocated_value_i),
    .rdata_o(alloc_rd)
  );

  bsc_ram #(
    .Width(VALUE_BITS),
    .Depth(TABLE_DEPTH)
  ) u_max_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .addr_i (table_addr),
    .wdata_i(maximum_value_i),
    .rdata_o(max_rd)
  );

  assign need = (max_rd > alloc_rd) ? (max_rd - alloc_rd) : '0;

  always_ff @(posedge clk_i) begin
    if (avail_we) begin
      avail_q[resource_index_i] <= available_value_i;
    end
    if (cmd_i.init_run) begin
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        work_q[i] <= (NRES_BITS'(i) < nr) ? WORK_BITS'(avail_q[i]) : '0;
      end
    end else if (cmd_i.work_add) begin
      work_q[r_q] <= work_q[r_q] + WORK_BITS'(alloc_rd);
    end
    if (cmd_i.commit) begin
      order_q[count_q[PID_BITS-1:0]] <= p_q[PID_BITS-1:0];
    end
    if (cmd_i.out_load_seq) begin
      pid_out_q  <= order_q[k_q];
      safe_out_q <= 1'b1;
      last_out_q <= (CNT_BITS'(k_q) + CNT_BITS'(1)) == np;
    end else if (cmd_i.out_load_unsafe) begin
      pid_out_q  <= '0;
      safe_out_q <= 1'b0;
      last_out_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q        <= '0;
      r_q        <= '0;
      count_q    <= '0;
      k_q        <= '0;
      finished_q <= '0;
    end else begin
      if (cmd_i.init_run || cmd_i.p_clear) begin
        p_q <= '0;
      end else if (cmd_i.p_next) begin
        p_q <= p_q + CNT_BITS'(1);
      end
      if (cmd_i.init_run || cmd_i.r_clear) begin
        r_q <= '0;
      end else if (cmd_i.r_next) begin
        r_q <= r_q + RID_BITS'(1);
      end
      if (cmd_i.init_run) begin
        count_q    <= '0;
        finished_q <= '0;
      end else if (cmd_i.commit) begin
        count_q <= count_q + CNT_BITS'(1);
        finished_q[p_q[PID_BITS-1:0]] <= 1'b1;
      end
      if (cmd_i.init_run) begin
        k_q <= '0;
      end else if (cmd_i.out_load_seq) begin
        k_q <= k_q + PID_BITS'(1);
      end
    end
  end

  assign stat_o.all_done   = (count_q == np);
  assign stat_o.p_end      = (p_q == np);
  assign stat_o.p_finished = finished_q[p_q[PID_BITS-1:0]];
  assign stat_o.r_last     = (NRES_BITS'(r_q) + NRES_BITS'(1)) == nr;
  assign stat_o.fits       = WORK_BITS'(need) <= work_q[r_q];
  assign stat_o.out_last   = last_out_q;

  assign process_id_o = pid_out_q;
  assign safe_o       = safe_out_q;
  assign last_o       = last_out_q;

endmodule

// ----- src/bsc_controller.sv -----
// Controller state machine of the Banker's safety check: sequences loads,
// the process scan, the need check, the work update and result delivery.
// Uses bsc_pkg.
module bsc_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bsc_pkg::CMD_BITS-1:0] command_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  bsc_pkg::dp_stat_t            stat_i,
  output bsc_pkg::ctl_cmd_t            cmd_o
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && (command_i == CMD_RUN)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_run = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.all_done) begin
          cmd_o.out_load_seq = 1'b1;
          state_d = ST_EMIT;
        end else if (stat_i.p_end) begin
          cmd_o.out_load_unsafe = 1'b1;
          state_d = ST_EMIT;
        end else if (stat_i.p_finished) begin
          cmd_o.p_next = 1'b1;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        state_d = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (!stat_i.fits) begin
          cmd_o.p_next  = 1'b1;
          cmd_o.r_clear = 1'b1;
          state_d = ST_SCAN;
        end else if (stat_i.r_last) begin
          cmd_o.r_clear = 1'b1;
          state_d = ST_ADD_RD;
        end else begin
          cmd_o.r_next = 1'b1;
          state_d = ST_CHK_RD;
        end
      end
      ST_ADD_RD: begin
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.work_add = 1'b1;
        if (stat_i.r_last) begin
          cmd_o.commit  = 1'b1;
          cmd_o.r_clear = 1'b1;
          cmd_o.p_clear = 1'b1;
          state_d = ST_SCAN;
        end else begin
          cmd_o.r_next = 1'b1;
          state_d = ST_ADD_RD;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.out_load_seq = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_d == ST_EMIT);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result is pending");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == CMD_RUN)) |=> !in_ready_o)
    else $error("input still open after a run item was accepted");

  a_commit_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (cmd_o.work_add && stat_i.r_last && !stat_i.p_finished))
    else $error("process committed twice or before its work update ended");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && stat_i.out_last) |=> (in_ready_o && !out_valid_o))
    else $error("block not idle after the final result of a run");

  a_exclusive_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.out_load_seq, cmd_o.out_load_unsafe, cmd_o.commit, cmd_o.init_run}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ----- src/bankers_safety_check_top.sv -----
// Banker's safety check. Load items (available entries and per-process
// allocated/maximum entries) are accepted one per cycle while the block is
// idle and produce no result. A run item blocks the input until its results
// are delivered: the run seeds the work vector, then scans the processes; for
// each unfinished candidate it reads and compares need against work one
// resource at a time (up to the first misfit), and for each process added to
// the sequence it reads and adds its allocation one resource at a time, all
// through the single port of the allocation and maximum tables; then one
// result per cycle while the sink is ready. Results are the safe sequence
// with the last item marked, or a single unsafe item.
// Uses bsc_pkg, bsc_controller, bsc_datapath.
module bankers_safety_check_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bsc_pkg::CMD_BITS-1:0]      command_i,
  input  logic [bsc_pkg::PID_BITS-1:0]      process_index_i,
  input  logic [bsc_pkg::RID_BITS-1:0]      resource_index_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    available_value_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    allocated_value_i,
  input  logic [bsc_pkg::VALUE_BITS-1:0]    maximum_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bsc_pkg::PID_BITS-1:0]      process_id_o,
  output logic                              safe_o,
  output logic                              last_o
);
  import bsc_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  bsc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  bsc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctl_cmd),
    .stat_o           (dp_stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .process_index_i  (process_index_i),
    .resource_index_i (resource_index_i),
    .available_value_i(available_value_i),
    .allocated_value_i(allocated_value_i),
    .maximum_value_i  (maximum_value_i),
    .process_id_o     (process_id_o),
    .safe_o           (safe_o),
    .last_o           (last_o)
  );

endmodule
